// ===== rtl/sacvl_pkg.sv =====
// Shared types and codes for the set-associative cache with victim lookup.
package sacvl_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_L1_RD,
      ST_L1_CMP,
      ST_VIC_SCAN,
      ST_MISS_FILL,
      ST_RESULT
   } state_type;

   localparam logic [1:0] OUTCOME_L1_HIT  = 2'd0;
   localparam logic [1:0] OUTCOME_VIC_HIT = 2'd1;
   localparam logic [1:0] OUTCOME_MISS    = 2'd2;

   localparam logic [1:0] CSR_BLOCK_SIZE_LOG2 = 2'd0;
   localparam logic [1:0] CSR_SETS_LOG2       = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE     = 2'd2;
   localparam logic [1:0] CSR_VICTIM_ENTRIES  = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic [31:0] stamp;
   } line_type;

endpackage

// ===== rtl/sacvl_line_ram.sv =====
// L1 line store: one write port, one registered read port.
module sacvl_line_ram import sacvl_pkg::*; #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  line_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output line_type      rd_data
);

   line_type mem [DEPTH];
   line_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== rtl/set_assoc_cache_with_victim_lookup.sv =====
// Top level: set-associative LRU tag cache with a victim cache, sequenced lookups.
// Per block lookup: a setup state, a read and a compare state per L1 way, a scan state per
// victim entry, a fill state on a miss and a result state; a read of N blocks repeats this.
// Throughput: one read at a time, busy high until its last result.
// Reset: synchronous; a clearing pass invalidates every one of the MAX_SETS*MAX_WAYS lines,
// busy stays high meanwhile. Results are strobed for one cycle; the receiver cannot stall.
module set_assoc_cache_with_victim_lookup import sacvl_pkg::*; #(
   parameter int MAX_SETS   = 256,
   parameter int MAX_WAYS   = 8,
   parameter int MAX_VICTIM = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_byte_address,
   input  logic [6:0]  req_read_length,
   input  logic [31:0] req_access_time,
   output logic        rsp_strobe,
   output logic [31:0] rsp_block_address,
   output logic [1:0]  rsp_outcome,
   output logic        rsp_moved_to_victim,
   output logic        rsp_last_block,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_write_data
);

   localparam int DEPTH   = MAX_SETS * MAX_WAYS;
   localparam int LINE_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int SL_MAX  = $clog2(MAX_SETS + 1) - 1;
   localparam int WAY_W   = $clog2(MAX_WAYS + 1);
   localparam int WIDX    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int VIC_W   = $clog2(MAX_VICTIM + 1);
   localparam int VIDX    = (MAX_VICTIM > 1) ? $clog2(MAX_VICTIM) : 1;

   // configuration registers
   logic [2:0] csr_bsl_ff;
   logic [3:0] csr_sl_ff;
   logic [3:0] csr_ways_ff;
   logic [3:0] csr_vic_ff;

   state_type state_ff, state_in;

   // clearing pass counter
   logic [LINE_AW-1:0] clr_ff, clr_in;

   // per-read context, latched on transfer
   logic [2:0]       bsl_ff, bsl_in;
   logic [SET_W-1:0] set_mask_ff, set_mask_in;
   logic [WAY_W-1:0] ways_ff, ways_in;
   logic [VIC_W-1:0] vic_ff, vic_in;
   logic [31:0]      stamp_ff, stamp_in;
   logic [31:0]      blk_ff, blk_in;
   logic [4:0]       remain_ff, remain_in;

   // per-block scan state
   logic [SET_W-1:0] set_ff, set_in;
   logic [WAY_W-1:0] way_ff, way_in;
   logic [VIC_W-1:0] vidx_ff, vidx_in;
   logic [WIDX-1:0]  w_idx_ff, w_idx_in;
   logic             w_valid_ff, w_valid_in;
   logic [31:0]      w_addr_ff, w_addr_in;
   logic [31:0]      w_stamp_ff, w_stamp_in;
   logic [VIDX-1:0]  v_idx_ff, v_idx_in;
   logic             v_valid_ff, v_valid_in;
   logic [31:0]      v_stamp_ff, v_stamp_in;
   logic [1:0]       outcome_ff, outcome_in;
   logic             moved_ff, moved_in;

   // victim store: small register file scanned one entry a cycle
   logic [31:0] vaddr_ff  [MAX_VICTIM];
   logic [31:0] vstamp_ff [MAX_VICTIM];
   logic        vvalid_ff [MAX_VICTIM];

   logic            vic_we;
   logic [VIDX-1:0] vic_wi;
   logic [31:0]     vic_wa;
   logic [31:0]     vic_ws;
   logic            vic_wv;

   // line RAM ports
   logic               ram_we;
   logic [LINE_AW-1:0] ram_wa;
   line_type           ram_wd;
   logic [LINE_AW-1:0] ram_ra;
   line_type           ram_rd;

   // transfer-time decode of the configuration and length
   logic [2:0]       bsl_c;
   logic [3:0]       sl_c;
   logic [WAY_W-1:0] ways_c;
   logic [VIC_W-1:0] vic_c;
   logic [6:0]       len_c;
   logic [6:0]       off_c;
   logic [6:0]       span_c;
   logic [31:0]      amask_c;

   // current-entry views
   logic [VIDX-1:0] vsel;
   logic            l1_hit;
   logic            vic_hit;
   logic            l1_last;
   logic            vic_last;
   logic [LINE_AW-1:0] entry_scan;
   logic [LINE_AW-1:0] entry_w;

   logic accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      bsl_c = csr_bsl_ff;
      if (csr_bsl_ff < 3'd2) begin
         bsl_c = 3'd2;
      end else if (csr_bsl_ff > 3'd6) begin
         bsl_c = 3'd6;
      end
      sl_c = (32'(csr_sl_ff) > 32'(SL_MAX)) ? 4'(SL_MAX) : csr_sl_ff;
      if (csr_ways_ff == 4'd0) begin
         ways_c = WAY_W'(1);
      end else if (5'(csr_ways_ff) > 5'(MAX_WAYS)) begin
         ways_c = WAY_W'(MAX_WAYS);
      end else begin
         ways_c = WAY_W'(csr_ways_ff);
      end
      vic_c = (6'(csr_vic_ff) > 6'(MAX_VICTIM)) ? VIC_W'(MAX_VICTIM) : VIC_W'(csr_vic_ff);
      // saturate the length to 1..64
      if (req_read_length == 7'd0) begin
         len_c = 7'd1;
      end else if (req_read_length > 7'd64) begin
         len_c = 7'd64;
      end else begin
         len_c = req_read_length;
      end
      amask_c = ~((32'd1 << bsl_c) - 32'd1);
      // offset within the first block plus the span gives the block count
      off_c  = {1'b0, req_byte_address[5:0]} & ~amask_c[6:0];
      span_c = off_c + len_c - 7'd1;
   end

   assign vsel       = vidx_ff[VIDX-1:0];
   assign l1_hit     = ram_rd.valid && (ram_rd.addr == blk_ff);
   assign vic_hit    = vvalid_ff[vsel] && (vaddr_ff[vsel] == blk_ff);
   assign l1_last    = (way_ff + WAY_W'(1)) == ways_ff;
   assign vic_last   = (vidx_ff + VIC_W'(1)) == vic_ff;
   assign entry_scan = LINE_AW'(set_ff) * LINE_AW'(MAX_WAYS) + LINE_AW'(way_ff[WIDX-1:0]);
   assign entry_w    = LINE_AW'(set_ff) * LINE_AW'(MAX_WAYS) + LINE_AW'(w_idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LINE_AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP:  state_in = ST_L1_RD;
         ST_L1_RD:  state_in = ST_L1_CMP;
         ST_L1_CMP: begin
            if (l1_hit) begin
               state_in = ST_RESULT;
            end else if (!l1_last) begin
               state_in = ST_L1_RD;
            end else if (vic_ff != '0) begin
               state_in = ST_VIC_SCAN;
            end else begin
               state_in = ST_MISS_FILL;
            end
         end
         ST_VIC_SCAN: begin
            if (vic_hit) begin
               state_in = ST_RESULT;
            end else if (vic_last) begin
               state_in = ST_MISS_FILL;
            end
         end
         ST_MISS_FILL: state_in = ST_RESULT;
         ST_RESULT: begin
            state_in = (remain_ff == 5'd1) ? ST_IDLE : ST_SETUP;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in      = clr_ff;
      bsl_in      = bsl_ff;
      set_mask_in = set_mask_ff;
      ways_in     = ways_ff;
      vic_in      = vic_ff;
      stamp_in    = stamp_ff;
      blk_in      = blk_ff;
      remain_in   = remain_ff;
      set_in      = set_ff;
      way_in      = way_ff;
      vidx_in     = vidx_ff;
      w_idx_in    = w_idx_ff;
      w_valid_in  = w_valid_ff;
      w_addr_in   = w_addr_ff;
      w_stamp_in  = w_stamp_ff;
      v_idx_in    = v_idx_ff;
      v_valid_in  = v_valid_ff;
      v_stamp_in  = v_stamp_ff;
      outcome_in  = outcome_ff;
      moved_in    = moved_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + LINE_AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               bsl_in      = bsl_c;
               set_mask_in = SET_W'((13'd1 << sl_c) - 13'd1);
               ways_in     = ways_c;
               vic_in      = vic_c;
               stamp_in    = req_access_time;
               blk_in      = req_byte_address & amask_c;
               remain_in   = 5'(span_c >> bsl_c) + 5'd1;
            end
         end
         ST_SETUP: begin
            set_in   = SET_W'(blk_ff >> bsl_ff) & set_mask_ff;
            way_in   = '0;
            moved_in = 1'b0;
         end
         ST_L1_CMP: begin
            // LRU: lowest invalid way, else smallest stamp with lowest index on a tie
            if ((way_ff == '0) ||
                (w_valid_ff && (!ram_rd.valid || (ram_rd.stamp < w_stamp_ff)))) begin
               w_idx_in   = way_ff[WIDX-1:0];
               w_valid_in = ram_rd.valid;
               w_addr_in  = ram_rd.addr;
               w_stamp_in = ram_rd.stamp;
            end
            way_in  = way_ff + WAY_W'(1);
            vidx_in = '0;
            if (l1_hit) begin
               outcome_in = OUTCOME_L1_HIT;
            end
         end
         ST_VIC_SCAN: begin
            if ((vidx_ff == '0) ||
                (v_valid_ff && (!vvalid_ff[vsel] || (vstamp_ff[vsel] < v_stamp_ff)))) begin
               v_idx_in   = vsel;
               v_valid_in = vvalid_ff[vsel];
               v_stamp_in = vstamp_ff[vsel];
            end
            vidx_in = vidx_ff + VIC_W'(1);
            if (vic_hit) begin
               outcome_in = OUTCOME_VIC_HIT;
               moved_in   = w_valid_ff;
            end
         end
         ST_MISS_FILL: begin
            outcome_in = OUTCOME_MISS;
            moved_in   = (vic_ff != '0) && w_valid_ff;
         end
         ST_RESULT: begin
            blk_in    = blk_ff + (32'd1 << bsl_ff);
            remain_in = remain_ff - 5'd1;
         end
         default: ;
      endcase
   end

   // outputs: RAM and victim writes, handshake
   always_comb begin
      ram_we = 1'b0;
      ram_wa = entry_w;
      ram_wd = '{valid: 1'b1, addr: blk_ff, stamp: stamp_ff};
      ram_ra = entry_scan;
      vic_we = 1'b0;
      vic_wi = vsel;
      vic_wa = w_addr_ff;
      vic_ws = w_stamp_ff;
      vic_wv = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            ram_wd = '{valid: 1'b0, addr: 32'd0, stamp: 32'd0};
         end
         ST_L1_CMP: begin
            // refresh the stamp of the hit line
            if (l1_hit) begin
               ram_we = 1'b1;
               ram_wa = entry_scan;
            end
         end
         ST_VIC_SCAN: begin
            // swap with the L1 LRU line, or drop the entry if that line is empty
            if (vic_hit) begin
               ram_we = 1'b1;
               vic_we = 1'b1;
               vic_wv = w_valid_ff;
            end
         end
         ST_MISS_FILL: begin
            ram_we = 1'b1;
            if ((vic_ff != '0) && w_valid_ff) begin
               vic_we = 1'b1;
               vic_wi = v_idx_ff;
            end
         end
         default: ;
      endcase
      busy                = (state_ff != ST_IDLE);
      rsp_strobe          = (state_ff == ST_RESULT);
      rsp_block_address   = blk_ff;
      rsp_outcome         = outcome_ff;
      rsp_moved_to_victim = moved_ff;
      rsp_last_block      = (remain_ff == 5'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         csr_bsl_ff  <= 3'd4;
         csr_sl_ff   <= 4'd6;
         csr_ways_ff <= 4'd2;
         csr_vic_ff  <= 4'd4;
         for (int i = 0; i < MAX_VICTIM; i++) begin
            vvalid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BLOCK_SIZE_LOG2: csr_bsl_ff  <= csr_write_data[2:0];
               CSR_SETS_LOG2:       csr_sl_ff   <= csr_write_data;
               CSR_WAYS_IN_USE:     csr_ways_ff <= csr_write_data;
               CSR_VICTIM_ENTRIES:  csr_vic_ff  <= csr_write_data;
               default: ;
            endcase
         end
         if (vic_we) begin
            vvalid_ff[vic_wi] <= vic_wv;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      bsl_ff      <= bsl_in;
      set_mask_ff <= set_mask_in;
      ways_ff     <= ways_in;
      vic_ff      <= vic_in;
      stamp_ff    <= stamp_in;
      blk_ff      <= blk_in;
      remain_ff   <= remain_in;
      set_ff      <= set_in;
      way_ff      <= way_in;
      vidx_ff     <= vidx_in;
      w_idx_ff    <= w_idx_in;
      w_valid_ff  <= w_valid_in;
      w_addr_ff   <= w_addr_in;
      w_stamp_ff  <= w_stamp_in;
      v_idx_ff    <= v_idx_in;
      v_valid_ff  <= v_valid_in;
      v_stamp_ff  <= v_stamp_in;
      outcome_ff  <= outcome_in;
      moved_ff    <= moved_in;
      if (vic_we) begin
         vaddr_ff[vic_wi]  <= vic_wa;
         vstamp_ff[vic_wi] <= vic_ws;
      end
   end

   sacvl_line_ram #(
      .DEPTH (DEPTH),
      .AW    (LINE_AW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

endmodule
